FILE: hw/rtl/vst_pkg.sv
// Package for the vertex to screen transform unit.
// Holds the item types, fixed-point constants and the pixel mapping function.
// Depends on nothing.
package vst_pkg;

  // Fixed-point format and screen size.
  localparam int FracBits = 16;
  localparam int XRes     = 1024;
  localparam int YRes     = 768;

  // Width of a homogeneous coordinate: floored product plus the carry of four terms.
  localparam int HW = 66 - FracBits;
  // Quotient bits of the homogeneous divide.
  localparam int QW = 32;
  // Divider depth: one setup stage, one stage per quotient bit, one sign stage.
  localparam int DivLat = QW + 2;
  // Pixel scale factors (RES - 1) div 2, and the product width of the mapping.
  localparam int SW = 14;
  localparam logic signed [SW-1:0] XScale = SW'((XRes - 1) / 2);
  localparam logic signed [SW-1:0] YScale = SW'((YRes - 1) / 2);
  localparam int PW = 34 + SW;
  localparam logic signed [33:0] OneQ = 34'(2 ** FracBits);
  localparam logic [12:0] XLim = 13'(XRes - 1);
  localparam logic [12:0] YLim = 13'(YRes - 1);

  // Configuration registers.
  localparam int NumCfgRegs = 8;
  localparam int CfgIdxW    = 4;
  localparam logic [63:0] OneHi = 64'(2 ** FracBits) << 32;
  localparam logic [63:0] OneLo = 64'(2 ** FracBits);

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic signed [31:0] depth;
    logic               off_screen;
    logic               w_zero;
  } out_item_t;

  typedef struct packed {
    logic [9:0] p;
    logic       off;
  } pix_t;

  // Truncate a scaled coordinate toward zero and saturate it to 0..lim.
  function automatic pix_t pix_map(input logic signed [PW-1:0] v, input logic [12:0] lim);
    pix_t r;
    logic [PW-FracBits-1:0] t;
    r = '0;
    if (v[PW-1]) begin
      t     = (PW - FracBits)'(PW'(-v) >> FracBits);
      r.off = (t != '0);
      r.p   = '0;
    end else begin
      t = (PW - FracBits)'(PW'(v) >> FracBits);
      if (t > (PW - FracBits)'(lim)) begin
        r.off = 1'b1;
        r.p   = lim[9:0];
      end else begin
        r.p = t[9:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/vst_div_pipe.sv
// Pipelined restoring divider for the homogeneous divide, one quotient bit per stage.
// Gives num * 2^FracBits / den truncated and saturated to signed 32 bits.
// Depends on vst_pkg.
module vst_div_pipe (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [vst_pkg::HW-1:0]    num_i,
  input  logic [vst_pkg::HW-1:0]    den_i,
  input  logic                      neg_i,
  output logic signed [31:0]        ndc_o
);

  localparam int Hw = vst_pkg::HW;
  localparam int Qw = vst_pkg::QW;
  localparam int Fb = vst_pkg::FracBits;

  logic [Hw-1:0] rem_q [0:Qw-1];
  logic [Hw-1:0] den_q [0:Qw-1];
  logic [Qw-1:0] low_q [0:Qw-1];
  logic [Qw-1:0] quo_q [0:Qw];
  logic          ovf_q [0:Qw];
  logic          neg_q [0:Qw];
  logic signed [31:0] ndc_q;

  // Setup stage: overflow check and the first partial remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= {{(Qw - Fb){1'b0}}, num_i} >= {den_i, {(Qw - Fb){1'b0}}};
      rem_q[0] <= Hw'(num_i >> (Qw - Fb));
      low_q[0] <= {num_i[Qw-Fb-1:0], {Fb{1'b0}}};
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
    end
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= Qw; k++) begin : g_step
    logic [Hw:0] trial;
    logic        ge;
    assign trial = {rem_q[k-1], low_q[k-1][Qw-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_q[k-1][Qw-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end

    if (k < Qw) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? Hw'(trial - {1'b0, den_q[k-1]}) : Hw'(trial);
          low_q[k] <= {low_q[k-1][Qw-2:0], 1'b0};
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  // Sign and saturation stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[Qw]) begin
        if (ovf_q[Qw] || (quo_q[Qw] > 32'h8000_0000)) ndc_q <= 32'sh8000_0000;
        else ndc_q <= -$signed(quo_q[Qw]);
      end else begin
        if (ovf_q[Qw] || quo_q[Qw][31]) ndc_q <= 32'sh7FFF_FFFF;
        else ndc_q <= $signed(quo_q[Qw]);
      end
    end
  end

  assign ndc_o = ndc_q;

endmodule

FILE: hw/rtl/vertex_to_screen_transform_unit.sv
// Top level of the vertex to screen transform unit.
// Depends on vst_pkg and vst_div_pipe.

// Takes one vertex per clock while the output is not stalled and returns one result
// per vertex in order. The latency is set mostly by the three homogeneous dividers,
// which resolve one quotient bit per stage (34 stages); the input register, matrix
// products, sums, magnitudes, pixel scaling and saturation take the rest. A stall at
// the output holds the whole pipeline, so the input is stalled in the same cycle.
// The matrix registers may be written at any time the unit is idle and reset to
// the identity.
module vertex_to_screen_transform_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  vst_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output vst_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vst_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);

  localparam int Hw    = vst_pkg::HW;
  localparam int Fb    = vst_pkg::FracBits;
  localparam int DivSt = 4;
  localparam int PixSt = DivSt + vst_pkg::DivLat;
  localparam int Last  = PixSt + 1;

  logic [63:0] cfg_q [0:vst_pkg::NumCfgRegs-1];
  logic        vld_q [0:Last];
  logic        adv;

  vst_pkg::in_item_t in_q;
  logic signed [63:0] prod_q [0:3][0:2];
  logic signed [Hw-1:0] h_q [0:3];
  logic [Hw-1:0] mag_q [0:3];
  logic          neg_q [0:2];
  logic          wz_q [0:vst_pkg::DivLat];
  logic signed [31:0] ndc [0:2];
  logic signed [vst_pkg::PW-1:0] sx_q, sy_q;
  logic signed [31:0] nz_q;
  logic               wzp_q;
  vst_pkg::out_item_t out_q;
  vst_pkg::pix_t      px, py;

  // The pipeline moves whenever the last stage is empty or being taken.
  assign adv         = !(vld_q[Last] && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Matrix registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= vst_pkg::OneHi;
      cfg_q[1] <= '0;
      cfg_q[2] <= vst_pkg::OneLo;
      cfg_q[3] <= '0;
      cfg_q[4] <= '0;
      cfg_q[5] <= vst_pkg::OneHi;
      cfg_q[6] <= '0;
      cfg_q[7] <= vst_pkg::OneLo;
    end else if (cfg_valid_i && (cfg_index_i < vst_pkg::CfgIdxW'(vst_pkg::NumCfgRegs))) begin
      cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Last; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= Last; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (adv) in_q <= in_item_i;
  end

  // Matrix entry by coordinate products, one multiplier each.
  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [31:0] c0, c1, c2, c3;
    assign c0 = $signed(cfg_q[2*r][63:32]);
    assign c1 = $signed(cfg_q[2*r][31:0]);
    assign c2 = $signed(cfg_q[2*r+1][63:32]);
    assign c3 = $signed(cfg_q[2*r+1][31:0]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        prod_q[r][0] <= c0 * in_q.world_x;
        prod_q[r][1] <= c1 * in_q.world_y;
        prod_q[r][2] <= c2 * in_q.world_z;
      end
    end

    // Floor each product to the fixed-point format and add the translation column.
    always_ff @(posedge clk_i) begin
      if (adv) begin
        h_q[r] <= Hw'(prod_q[r][0] >>> Fb) + Hw'(prod_q[r][1] >>> Fb)
                + Hw'(prod_q[r][2] >>> Fb) + Hw'(c3);
      end
    end
  end

  // Magnitudes and quotient signs for the divide; the w zero flag follows the dividers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        mag_q[r] <= h_q[r][Hw-1] ? Hw'(-h_q[r]) : Hw'(h_q[r]);
      end
      for (int r = 0; r < 3; r++) begin
        neg_q[r] <= h_q[r][Hw-1] ^ h_q[3][Hw-1];
      end
      wz_q[0] <= (h_q[3] == '0);
      for (int i = 1; i <= vst_pkg::DivLat; i++) wz_q[i] <= wz_q[i-1];
    end
  end

  for (genvar d = 0; d < 3; d++) begin : g_div
    vst_div_pipe u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mag_q[d]),
      .den_i (mag_q[3]),
      .neg_i (neg_q[d]),
      .ndc_o (ndc[d])
    );
  end

  // Scale NDC x and flipped y to pixel units.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q  <= ($signed({{2{ndc[0][31]}}, ndc[0]}) + vst_pkg::OneQ) * vst_pkg::XScale;
      sy_q  <= (vst_pkg::OneQ - $signed({{2{ndc[1][31]}}, ndc[1]})) * vst_pkg::YScale;
      nz_q  <= ndc[2];
      wzp_q <= wz_q[vst_pkg::DivLat];
    end
  end

  assign px = vst_pkg::pix_map(sx_q, vst_pkg::XLim);
  assign py = vst_pkg::pix_map(sy_q, vst_pkg::YLim);

  // Output register: truncate, saturate, and clear everything when w was zero.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (wzp_q) begin
        out_q        <= '0;
        out_q.w_zero <= 1'b1;
      end else begin
        out_q.pixel_x    <= px.p;
        out_q.pixel_y    <= py.p;
        out_q.depth      <= nz_q;
        out_q.off_screen <= px.off || py.off;
        out_q.w_zero     <= 1'b0;
      end
    end
  end

  assign out_valid_o = vld_q[Last];
  assign out_item_o  = out_q;

  // The input is held back only by a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // Pixel rows stay on screen.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.pixel_y <= vst_pkg::YLim[9:0]))
    else $error("pixel row beyond screen");

  // A zero w clears every other field.
  a_wzero_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.w_zero) |->
      (out_item_o.pixel_x == '0 && out_item_o.pixel_y == '0 &&
       out_item_o.depth == '0 && !out_item_o.off_screen))
    else $error("w zero result has nonzero fields");

endmodule

FILE: tb/sv/vst_checker.sv
// Checker for the vertex to screen transform unit: watches the vertex, result and
// matrix write channels, predicts each screen result and compares it field by field.
// Depends on vst_pkg.
module vst_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  vst_pkg::in_item_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  vst_pkg::out_item_t          out_item_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [3:0]                  cfg_index_i,
  input  logic [63:0]                 cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0]        matrix_q [vst_pkg::NumCfgRegs];
  vst_pkg::out_item_t screen_fifo [$];

  // Floor of v / 2^FracBits.
  function automatic longint floor_q(input longint v);
    return v >>> vst_pkg::FracBits;
  endfunction

  // Homogeneous coordinate for one matrix row.
  function automatic longint row_sum(input int r, input longint x, input longint y,
                                     input longint z);
    logic signed [31:0] c0, c1, c2, c3;
    c0 = matrix_q[2*r][63:32];
    c1 = matrix_q[2*r][31:0];
    c2 = matrix_q[2*r+1][63:32];
    c3 = matrix_q[2*r+1][31:0];
    return floor_q(longint'(c0) * x) + floor_q(longint'(c1) * y) +
           floor_q(longint'(c2) * z) + longint'(c3);
  endfunction

  // Quotient num / den in Q16.16, truncated toward zero and saturated.
  function automatic longint ndc_div(input longint num, input longint den);
    logic        neg;
    logic [63:0] un, ud, ip, rem, q;
    longint      v;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? -num : num;
    ud  = (den < 0) ? -den : den;
    ip  = un / ud;
    rem = un % ud;
    if (ip >= (64'd1 << (32 - vst_pkg::FracBits))) begin
      q = 64'd1 << 32;
    end else begin
      q = ip << vst_pkg::FracBits;
      for (int i = 0; i < vst_pkg::FracBits; i++) begin
        rem = rem << 1;
        if (rem >= ud) begin
          rem = rem - ud;
          q[vst_pkg::FracBits-1-i] = 1'b1;
        end
      end
    end
    v = neg ? -longint'(q) : longint'(q);
    if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
    if (v < -64'sh80000000) v = -64'sh80000000;
    return v;
  endfunction

  // Pixel from an NDC value: truncate toward zero, then clamp to the screen.
  function automatic longint ndc_to_pixel(input longint n, input longint res,
                                          inout logic off);
    longint prod, p;
    prod = (n + (64'sd1 <<< vst_pkg::FracBits)) * ((res - 1) / 2);
    p = (prod >= 0) ? (prod >>> vst_pkg::FracBits) : -((-prod) >>> vst_pkg::FracBits);
    if (p < 0) begin
      off = 1'b1;
      p = 0;
    end
    if (p > res - 1) begin
      off = 1'b1;
      p = res - 1;
    end
    return p;
  endfunction

  function automatic vst_pkg::out_item_t project_vertex(input vst_pkg::in_item_t v);
    vst_pkg::out_item_t o;
    longint    x, y, z, hx, hy, hz, hw, nx, ny;
    logic      off;
    x  = v.world_x;
    y  = v.world_y;
    z  = v.world_z;
    hx = row_sum(0, x, y, z);
    hy = row_sum(1, x, y, z);
    hz = row_sum(2, x, y, z);
    hw = row_sum(3, x, y, z);
    o  = '0;
    off = 1'b0;
    if (hw == 0) begin
      o.w_zero = 1'b1;
      return o;
    end
    nx = ndc_div(hx, hw);
    ny = ndc_div(hy, hw);
    o.depth   = 32'(ndc_div(hz, hw));
    o.pixel_x = 10'(ndc_to_pixel(nx, vst_pkg::XRes, off));
    o.pixel_y = 10'(ndc_to_pixel(-ny, vst_pkg::YRes, off));
    o.off_screen = off;
    return o;
  endfunction

  // Track matrix writes, predict on accepted vertices, compare accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    vst_pkg::out_item_t e;
    if (!rst_ni) begin
      matrix_q[0] <= vst_pkg::OneHi; matrix_q[1] <= '0;
      matrix_q[2] <= vst_pkg::OneLo; matrix_q[3] <= '0;
      matrix_q[4] <= '0;             matrix_q[5] <= vst_pkg::OneHi;
      matrix_q[6] <= '0;             matrix_q[7] <= vst_pkg::OneLo;
      screen_fifo.delete();
      fail_count_o <= 0;
      results_seen_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < vst_pkg::NumCfgRegs)
        matrix_q[cfg_index_i[2:0]] <= cfg_data_i;
      if (in_valid_i && !in_stall_i)
        screen_fifo = {screen_fifo, project_vertex(in_item_i)};
      if (out_valid_i && !out_stall_i) begin
        results_seen_o <= results_seen_o + 1;
        if (screen_fifo.size() == 0) begin
          $error("result with no vertex outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = screen_fifo.pop_front();
          if (out_item_i !== e) begin
            if (out_item_i.pixel_x !== e.pixel_x)
              $error("pixel_x expected %0d got %0d", e.pixel_x, out_item_i.pixel_x);
            if (out_item_i.pixel_y !== e.pixel_y)
              $error("pixel_y expected %0d got %0d", e.pixel_y, out_item_i.pixel_y);
            if (out_item_i.depth !== e.depth)
              $error("depth expected %h got %h", e.depth, out_item_i.depth);
            if (out_item_i.off_screen !== e.off_screen)
              $error("off_screen expected %b got %b", e.off_screen,
                     out_item_i.off_screen);
            if (out_item_i.w_zero !== e.w_zero)
              $error("w_zero expected %b got %b", e.w_zero, out_item_i.w_zero);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= screen_fifo.size();
    end
  end
endmodule

FILE: tb/sv/vertex_to_screen_transform_unit_tb.sv
// Testbench top for the vertex to screen transform unit: clock, reset, matrix
// writes, vertex stimulus with idling phases, and the verdict.
// Depends on vst_pkg, vst_checker and the unit itself.
module vertex_to_screen_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency   = 40;
  localparam int CycleCap  = 400000;

  logic               clk, rst_n;
  logic               in_valid, in_stall, out_valid, out_stall;
  vst_pkg::in_item_t  in_item;
  vst_pkg::out_item_t out_item;
  logic               cfg_valid, cfg_ready;
  logic [3:0]         cfg_index;
  logic [63:0]        cfg_data;
  int                 fail_count, pending, results_seen, cycle_count;
  int                 send_idle_pct, stall_pct;
  int                 vertices_sent;

  vertex_to_screen_transform_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  vst_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // One register write; ready is sampled mid-cycle, ahead of the deciding edge.
  task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
    logic ready;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ready = cfg_ready;
      @(posedge clk);
    end while (!ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(input logic [63:0] m [8]);
    for (int i = 0; i < 8; i++) write_reg(4'(i), m[i]);
  endtask

  // Present one vertex, honoring the sender idle rate, and hold it until taken.
  // Valid stays high after the item is taken so the next one can follow at once.
  task automatic send_vertex(input vst_pkg::in_item_t v);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= v;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    vertices_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] q16(input int whole);
    return 32'(whole) << 16;
  endfunction

  // Mostly moderate coordinates that land near the screen, some raw bit patterns.
  function automatic vst_pkg::in_item_t random_vertex();
    vst_pkg::in_item_t v;
    if ($urandom_range(9) < 2) begin
      v.world_x = $urandom();
      v.world_y = $urandom();
      v.world_z = $urandom();
    end else begin
      v.world_x = 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      v.world_y = 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      v.world_z = 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    end
    return v;
  endfunction

  function automatic logic [63:0] pack2(input logic [31:0] a, input logic [31:0] b);
    return {a, b};
  endfunction

  initial begin
    logic [63:0] persp [8];
    logic [63:0] wild [8];
    logic [63:0] ident [8];
    vst_pkg::in_item_t v;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    vertices_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vertices on the reset identity: w is always one here.
    send_vertex('{q16(0), q16(0), q16(0)});
    send_vertex('{q16(1), q16(-1), q16(1)});
    send_vertex('{q16(-1), q16(1), q16(-1)});
    send_vertex('{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000});
    send_vertex('{q16(2), q16(-2), q16(3)});
    send_vertex('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_vertex('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    // Slightly negative pixel before truncation counts as on screen.
    send_vertex('{32'hFFFF_FFFF - 32'h0000_FFFF, q16(1) + 1, q16(0)});
    send_vertex('{32'hFFFE_FFF0, 32'h0001_0010, 32'h0});
    drain();

    // Perspective: w = z, so z = 0 gives a zero w and negative z flips sides.
    ident = '{vst_pkg::OneHi, 64'h0, vst_pkg::OneLo, 64'h0, 64'h0, vst_pkg::OneHi,
              64'h0, vst_pkg::OneLo};
    persp = '{vst_pkg::OneHi, 64'h0, vst_pkg::OneLo, 64'h0, 64'h0,
              pack2(q16(1), q16(-1)), 64'h0, pack2(q16(1), 32'h0)};
    load_matrix(persp);
    send_vertex('{q16(1), q16(1), q16(0)});
    send_vertex('{q16(1), q16(1), q16(2)});
    send_vertex('{q16(-1), q16(1), q16(-2)});
    send_vertex('{q16(3), q16(0), 32'h0000_0001});
    send_vertex('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001});
    send_vertex('{q16(0), q16(0), 32'hFFFF_FFFF});
    drain();

    // Extreme entries in every register.
    wild = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_7FFF_FFFF,
             64'h7FFF_FFFF_8000_0000, 64'h0000_0000_FFFF_FFFF,
             64'h8000_0000_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF,
             64'h0000_0001_0000_0000, 64'h8000_0000_0000_0001};
    load_matrix(wild);
    send_vertex('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_vertex('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vertex('{q16(1), q16(0), q16(0)});
    send_vertex('{q16(0), q16(0), q16(0)});
    drain();
    // Out-of-range index is ignored.
    write_reg(4'd15, 64'hDEAD_BEEF_0000_0000);

    // Random phases: four idling patterns over several matrices.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      if (ph == 0) load_matrix(ident);
      else if (ph == 1) load_matrix(persp);
      else begin
        // Random projection: small random entries in every row, sometimes one raw register.
        for (int i = 0; i < 8; i++)
          wild[i] = pack2(32'($signed($urandom_range(4 << 16)) - (2 << 16)),
                          32'($signed($urandom_range(4 << 16)) - (2 << 16)));
        if ($urandom_range(3) == 0) wild[$urandom_range(7)] = {$urandom(), $urandom()};
        load_matrix(wild);
      end
      for (int n = 0; n < 140; n++) send_vertex(random_vertex());
      send_idle_pct = 0;
      stall_pct = 0;
      drain();
    end

    $display("Ran %0d vertices, %0d results checked, over identity, perspective,",
             vertices_sent, results_seen);
    $display("extreme and random matrices with four idling patterns.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
